/* src/tksel_pkg.sv */
// Shared constants and types for the top-k score selection block.
`timescale 1ns / 1ps
`default_nettype none

package tksel_pkg;

  localparam int unsigned LIST_SIZE_DEF = 10;
  localparam int unsigned TAG_BITS_DEF  = 16;

  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned IN_TAG_W  = 16;
  localparam int unsigned RANK_W    = 4;
  localparam int unsigned S_DATA_W  = 48;
  localparam int unsigned M_DATA_W  = 56;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [SCORE_W-1:0] MIN_SCORE_RST = 32'd6553;

  localparam logic REG_MIN_SCORE = 1'b0;

  typedef struct packed {
    logic                insert;
    logic                drain;
    logic [SCORE_W-1:0]  score;
  } row_ctrl_t;

endpackage

`default_nettype wire

/* src/tksel_cell.sv */
// One slot of the ranked row: holds a score and tag and trades them with its neighbours.
`timescale 1ns / 1ps
`default_nettype none

module tksel_cell #(
  parameter int unsigned TAG_W = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire tksel_pkg::row_ctrl_t    ctrl_i,
  input  wire [TAG_W-1:0]              new_tag_i,
  input  wire                          prev_beats_i,
  input  wire                          prev_used_i,
  input  wire [tksel_pkg::SCORE_W-1:0] prev_score_i,
  input  wire [TAG_W-1:0]              prev_tag_i,
  input  wire                          next_used_i,
  input  wire [tksel_pkg::SCORE_W-1:0] next_score_i,
  input  wire [TAG_W-1:0]              next_tag_i,
  output logic                         beats_o,
  output logic                         used_o,
  output logic [tksel_pkg::SCORE_W-1:0] score_o,
  output logic [TAG_W-1:0]             tag_o
);

  logic                         used_q, used_d;
  logic [tksel_pkg::SCORE_W-1:0] score_q, score_d;
  logic [TAG_W-1:0]             tag_q, tag_d;

  assign beats_o = !used_q || (score_q < ctrl_i.score);

  always_comb begin
    used_d  = used_q;
    score_d = score_q;
    tag_d   = tag_q;
    if (ctrl_i.drain) begin
      used_d  = next_used_i;
      score_d = next_score_i;
      tag_d   = next_tag_i;
    end else if (ctrl_i.insert) begin
      if (prev_beats_i) begin
        used_d  = prev_used_i;
        score_d = prev_score_i;
        tag_d   = prev_tag_i;
      end else if (beats_o) begin
        used_d  = 1'b1;
        score_d = ctrl_i.score;
        tag_d   = new_tag_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
    end else begin
      used_q <= used_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    tag_q   <= tag_d;
  end

  assign used_o  = used_q;
  assign score_o = score_q;
  assign tag_o   = tag_q;

endmodule

`default_nettype wire

/* src/tksel_row.sv */
// Row of ranked slots: insertion shifts towards the tail, readout shifts towards the head.
`timescale 1ns / 1ps
`default_nettype none

module tksel_row #(
  parameter int unsigned LIST_SIZE = tksel_pkg::LIST_SIZE_DEF,
  parameter int unsigned TAG_W     = tksel_pkg::IN_TAG_W
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire tksel_pkg::row_ctrl_t     ctrl_i,
  input  wire [TAG_W-1:0]               new_tag_i,
  output logic                          head_used_o,
  output logic [tksel_pkg::SCORE_W-1:0] head_score_o,
  output logic [TAG_W-1:0]              head_tag_o
);

  logic                          beats_w [LIST_SIZE];
  logic                          used_w  [LIST_SIZE];
  logic [tksel_pkg::SCORE_W-1:0] score_w [LIST_SIZE];
  logic [TAG_W-1:0]              tag_w   [LIST_SIZE];

  for (genvar i = 0; i < LIST_SIZE; i++) begin : g_cell
    logic                          prev_beats, prev_used, next_used;
    logic [tksel_pkg::SCORE_W-1:0] prev_score, next_score;
    logic [TAG_W-1:0]              prev_tag, next_tag;

    if (i == 0) begin : g_head
      assign prev_beats = 1'b0;
      assign prev_used  = 1'b0;
      assign prev_score = '0;
      assign prev_tag   = '0;
    end else begin : g_body
      assign prev_beats = beats_w[i-1];
      assign prev_used  = used_w[i-1];
      assign prev_score = score_w[i-1];
      assign prev_tag   = tag_w[i-1];
    end

    if (i == LIST_SIZE - 1) begin : g_tail
      assign next_used  = 1'b0;
      assign next_score = '0;
      assign next_tag   = '0;
    end else begin : g_link
      assign next_used  = used_w[i+1];
      assign next_score = score_w[i+1];
      assign next_tag   = tag_w[i+1];
    end

    tksel_cell #(
      .TAG_W(TAG_W)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl_i),
      .new_tag_i   (new_tag_i),
      .prev_beats_i(prev_beats),
      .prev_used_i (prev_used),
      .prev_score_i(prev_score),
      .prev_tag_i  (prev_tag),
      .next_used_i (next_used),
      .next_score_i(next_score),
      .next_tag_i  (next_tag),
      .beats_o     (beats_w[i]),
      .used_o      (used_w[i]),
      .score_o     (score_w[i]),
      .tag_o       (tag_w[i])
    );
  end

  assign head_used_o  = used_w[0];
  assign head_score_o = score_w[0];
  assign head_tag_o   = tag_w[0];

endmodule

`default_nettype wire

/* src/top_k_score_select_core.sv */
// Top level of the top-k score selection block: stream ports, threshold register, readout.
//
//   channel   dir  handshake                    payload
//   s_axis    in   s_axis_tvalid/tready         tdata: score, tag; tlast: is_last
//   m_axis    out  m_axis_tvalid/tready         tdata: rank, out_score, out_tag;
//                                               tuser: slot_valid; tlast: last_of_list
//   apb       in   psel/penable, pready high    min_score at address 0
//
// An accepted item scoring above min_score is offered to the row; every slot compares against it in parallel.
// An item with tlast starts a readout of LIST_SIZE results shifted out of the row head,
// one per cycle unless the output stalls; input is held off until the last result is loaded for output.
// The readout empties the row as it goes, so it needs no separate clearing pass.
// Reset empties the row and sets min_score to 6553.
`timescale 1ns / 1ps
`default_nettype none

module top_k_score_select_core #(
  parameter int unsigned LIST_SIZE = tksel_pkg::LIST_SIZE_DEF,
  parameter int unsigned TAG_BITS  = tksel_pkg::TAG_BITS_DEF
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  // [31:0] score, [47:32] tag
  input  wire [tksel_pkg::S_DATA_W-1:0]    s_axis_tdata,
  input  wire                              s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  // [3:0] rank, [35:4] out_score, [51:36] out_tag, [55:52] zero
  output logic [tksel_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // [0] slot_valid
  output logic                             m_axis_tuser,
  output logic                             m_axis_tlast,
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [tksel_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire [tksel_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [tksel_pkg::APB_DATA_W-1:0] prdata,
  output logic                             pready
);

  localparam int unsigned TAG_W = (TAG_BITS < tksel_pkg::IN_TAG_W) ? TAG_BITS
                                                                    : tksel_pkg::IN_TAG_W;
  localparam int unsigned CNT_W = (LIST_SIZE > 1) ? $clog2(LIST_SIZE) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIST_SIZE - 1);

  typedef enum logic [1:0] {
    ST_FILL  = 2'b01,
    ST_DRAIN = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [tksel_pkg::SCORE_W-1:0] min_score_q, min_score_d;

  logic                          out_valid_q, out_valid_d;
  logic [tksel_pkg::RANK_W-1:0]  out_rank_q, out_rank_d;
  logic [tksel_pkg::SCORE_W-1:0] out_score_q, out_score_d;
  logic [tksel_pkg::IN_TAG_W-1:0] out_tag_q, out_tag_d;
  logic                          out_used_q, out_used_d;
  logic                          out_last_q, out_last_d;

  logic                          in_acc, cfg_wr, load;
  logic [tksel_pkg::SCORE_W-1:0] in_score;
  logic [TAG_W-1:0]              in_tag;
  logic [6:0]                    cnt_ext;
  tksel_pkg::row_ctrl_t          ctrl;
  logic                          head_used;
  logic [tksel_pkg::SCORE_W-1:0] head_score;
  logic [TAG_W-1:0]              head_tag;

  assign in_score = s_axis_tdata[tksel_pkg::SCORE_W-1:0];
  assign in_tag   = s_axis_tdata[tksel_pkg::SCORE_W +: TAG_W];

  assign s_axis_tready = (state_q == ST_FILL);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load          = (state_q == ST_DRAIN) && (!out_valid_q || m_axis_tready);

  assign ctrl.insert = in_acc && (in_score > min_score_q);
  assign ctrl.drain  = load;
  assign ctrl.score  = in_score;

  tksel_row #(
    .LIST_SIZE(LIST_SIZE),
    .TAG_W    (TAG_W)
  ) u_row (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .new_tag_i   (in_tag),
    .head_used_o (head_used),
    .head_score_o(head_score),
    .head_tag_o  (head_tag)
  );

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == tksel_pkg::REG_MIN_SCORE) ? min_score_q : '0;

  always_comb begin
    min_score_d = min_score_q;
    if (cfg_wr && (paddr[2] == tksel_pkg::REG_MIN_SCORE)) begin
      min_score_d = pwdata;
    end
  end

  assign cnt_ext = 7'(cnt_q);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_rank_d  = out_rank_q;
    out_score_d = out_score_q;
    out_tag_d   = out_tag_q;
    out_used_d  = out_used_q;
    out_last_d  = out_last_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_FILL: begin
        if (in_acc && s_axis_tlast) begin
          state_d = ST_DRAIN;
          cnt_d   = '0;
        end
      end
      ST_DRAIN: begin
        if (load) begin
          out_valid_d = 1'b1;
          out_rank_d  = cnt_ext[tksel_pkg::RANK_W-1:0];
          out_used_d  = head_used;
          out_score_d = head_used ? head_score : '0;
          out_tag_d   = head_used ? tksel_pkg::IN_TAG_W'(head_tag) : '0;
          out_last_d  = (cnt_q == CNT_LAST);
          if (cnt_q == CNT_LAST) begin
            state_d = ST_FILL;
          end else begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = ST_FILL;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_FILL;
      cnt_q       <= '0;
      min_score_q <= tksel_pkg::MIN_SCORE_RST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      min_score_q <= min_score_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_rank_q  <= out_rank_d;
    out_score_q <= out_score_d;
    out_tag_q   <= out_tag_d;
    out_used_q  <= out_used_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_tag_q, out_score_q, out_rank_q};
  assign m_axis_tuser  = out_used_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

/* src/tksel_checker.sv */
// Port-level checks on the top-k score selection block, bound to its top level.
`timescale 1ns / 1ps
`default_nettype none

module tksel_checker #(
  parameter int unsigned LIST_SIZE = tksel_pkg::LIST_SIZE_DEF
) (
  input wire                            clk_i,
  input wire                            rst_ni,
  input wire                            s_axis_tvalid,
  input wire                            s_axis_tready,
  input wire                            s_axis_tlast,
  input wire                            m_axis_tvalid,
  input wire                            m_axis_tready,
  input wire [tksel_pkg::M_DATA_W-1:0]  m_axis_tdata,
  input wire                            m_axis_tuser,
  input wire                            m_axis_tlast
);

  localparam logic [tksel_pkg::RANK_W-1:0] RANK_LAST = tksel_pkg::RANK_W'(LIST_SIZE - 1);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input not held off after last item");

  a_last_rank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[3:0] == RANK_LAST)
    else $error("final item of readout has wrong rank");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[51:4] == '0)
    else $error("empty slot carries non-zero score or tag");

  a_readout_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid)
    else $error("readout gap after a taken item");

endmodule

bind top_k_score_select_core tksel_checker #(
  .LIST_SIZE(LIST_SIZE)
) u_tksel_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tlast (s_axis_tlast),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);

`default_nettype wire
